FILE: src/qtn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtn_pkg: shared types and constants of the query text normaliser
// token classes, emitted characters, result slots and payload structs
// ----------------------------------------------------------------------------
package qtn_pkg;

  localparam int IDENT_LIMIT_DEF = 36;

  // token classes from the lexer
  localparam logic [3:0] CLS_BLANK   = 4'd0;
  localparam logic [3:0] CLS_LITERAL = 4'd1;
  localparam logic [3:0] CLS_COMMA   = 4'd2;
  localparam logic [3:0] CLS_PLUS    = 4'd3;
  localparam logic [3:0] CLS_MINUS   = 4'd4;
  localparam logic [3:0] CLS_QUOTED  = 4'd5;
  localparam logic [3:0] CLS_WORD    = 4'd6;
  localparam logic [3:0] CLS_END     = 4'd8;
  localparam logic [3:0] CLS_ERROR   = 4'd9;

  // characters
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // fixed result slots, emitted lowest first
  localparam int SLOT_BLANK = 0;
  localparam int SLOT_QMARK = 1;
  localparam int SLOT_DOT_A = 2;
  localparam int SLOT_DOT_B = 3;
  localparam int SLOT_COMMA = 4;
  localparam int SLOT_SPACE = 5;
  localparam int SLOT_COPY  = 6;
  localparam int SLOT_BQ_A  = 7;
  localparam int SLOT_HIDE  = 8;
  localparam int SLOT_BQ_B  = 9;
  localparam int NSLOT      = 10;

  typedef logic [NSLOT-1:0] slot_mask_t;

  typedef struct packed {
    logic       first_of_query;
    logic [3:0] token_class;
    logic       first_byte;
    logic       last_byte;
    logic       next_is_paren;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       query_done;
  } res_item_t;

  // fixed part of the output of one input byte
  typedef struct packed {
    slot_mask_t mask;
    logic [7:0] chr;
    logic       done;
  } plan_t;

  function automatic logic [7:0] slot_char(input int slot, input logic [7:0] c);
    logic [7:0] r;
    case (slot)
      SLOT_BLANK: r = CH_SPACE;
      SLOT_QMARK: r = CH_QMARK;
      SLOT_DOT_A: r = CH_DOT;
      SLOT_DOT_B: r = CH_DOT;
      SLOT_COMMA: r = CH_COMMA;
      SLOT_SPACE: r = CH_SPACE;
      SLOT_COPY:  r = c;
      SLOT_BQ_A:  r = CH_BQUOTE;
      SLOT_HIDE:  r = CH_QMARK;
      SLOT_BQ_B:  r = CH_BQUOTE;
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/query_text_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// query_text_normalizer: normalised query text from lexed sql bytes
// collapses literals, held commas and blank runs, hides complex identifiers
// ----------------------------------------------------------------------------
// One input byte is taken per transfer and the block then stalls its input
// until every result byte of that input has been loaded into the output
// register. The fixed result bytes (question mark, dots, held comma or space,
// copied byte, hidden-name marker) are loaded first, one after another. The
// last byte of a buffered identifier then drains the identifier buffer: each
// byte is read from that memory in the S_READ state and sent in S_SEND, and
// output stalls hold the sequence. The verbatim-names register is sampled on
// a token's first byte and should only be written while the block is idle;
// the write channel is always ready. The identifier buffer has no reset: only
// entries written during the current identifier are ever read back.
// ----------------------------------------------------------------------------
module query_text_normalizer #(
  parameter int IDENT_LIMIT = qtn_pkg::IDENT_LIMIT_DEF,
  localparam int LEN_W  = $clog2(IDENT_LIMIT + 1),
  localparam int ADDR_W = $clog2(IDENT_LIMIT)
) (
  input  logic               clk,
  input  logic               rst,
  // input byte channel
  input  qtn_pkg::in_item_t  in_item,
  input  logic               in_valid,
  output logic               in_stall,
  // result channel
  output qtn_pkg::res_item_t res_item,
  output logic               res_valid,
  input  logic               res_stall,
  // verbatim-names write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import qtn_pkg::*;

  logic              in_accept;
  plan_t             plan;
  logic [LEN_W-1:0]  drain_len;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              busy;

  // input transfer only while the sequencer is idle
  assign in_stall  = busy;
  assign in_accept = in_valid & ~in_stall;
  // register writes never wait
  assign cfg_ready = 1'b1;

  // running query state, decode of each byte into a result plan
  qtn_token_ctl #(
    .IDENT_LIMIT(IDENT_LIMIT)
  ) u_ctl (
    .clk      (clk),
    .rst      (rst),
    .item     (in_item),
    .accept   (in_accept),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_keep (cfg_data),
    .plan     (plan),
    .drain_len(drain_len),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  // identifier bytes held until the name is judged
  qtn_ident_ram #(
    .DEPTH(IDENT_LIMIT)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // fixed characters first, then the buffered name, through the output register
  qtn_emit_seq #(
    .IDENT_LIMIT(IDENT_LIMIT)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .load     (in_accept),
    .plan     (plan),
    .drain_len(drain_len),
    .busy     (busy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .res_item (res_item),
    .res_valid(res_valid),
    .res_stall(res_stall)
  );

  // an empty result only ever marks the end of a query
  a_empty_is_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_item.char_valid) |-> res_item.query_done)
    else $error("empty result without query_done");

  // an end or error token never drains the identifier buffer
  a_done_no_drain: assert property (@(posedge clk) disable iff (rst)
    (in_accept && plan.done) |-> (drain_len == '0))
    else $error("end token with buffer drain");

  // buffer writes stay inside the identifier limit
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (int'(wr_addr) < IDENT_LIMIT))
    else $error("identifier buffer write out of range");

  // the buffer is never written while it is being drained
  a_no_wr_in_drain: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !wr_en)
    else $error("buffer write during drain");

endmodule
`default_nettype wire

FILE: src/qtn_ident_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtn_ident_ram: identifier buffer
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module qtn_ident_ram #(
  parameter int DEPTH = qtn_pkg::IDENT_LIMIT_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: src/qtn_token_ctl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtn_token_ctl: token state and decode
// running query state, identifier test and the result plan of each byte
// ----------------------------------------------------------------------------
module qtn_token_ctl #(
  parameter int IDENT_LIMIT = qtn_pkg::IDENT_LIMIT_DEF,
  localparam int LEN_W  = $clog2(IDENT_LIMIT + 1),
  localparam int ADDR_W = $clog2(IDENT_LIMIT)
) (
  input  logic              clk,
  input  logic              rst,
  input  qtn_pkg::in_item_t item,
  input  logic              accept,
  input  logic              cfg_we,
  input  logic              cfg_keep,
  output qtn_pkg::plan_t    plan,
  output logic [LEN_W-1:0]  drain_len,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data
);
  import qtn_pkg::*;

  typedef enum logic [1:0] {
    MODE_DROP,
    MODE_COPY,
    MODE_BUF,
    MODE_OVER
  } mode_t;

  logic             verbatim_names;
  logic             in_blank_run, in_blank_run_next;
  logic [1:0]       literal_run, literal_run_next;
  logic             pending_comma, pending_comma_next;
  logic             pending_space, pending_space_next;
  logic             at_query_start, at_query_start_next;
  mode_t            token_mode, token_mode_next;
  logic [LEN_W-1:0] ident_length, ident_length_next;
  logic [1:0]       digit_count, digit_count_next;
  logic             ident_complex, ident_complex_next;

  logic fb, was_start, go_on, skip, is_space, is_digit, wr_hit;
  logic [3:0] cls;

  assign cls      = item.token_class;
  assign is_space = (item.char_in == CH_SPACE) ||
                    (item.char_in >= CH_TAB && item.char_in <= CH_CR);
  assign is_digit = (item.char_in >= CH_ZERO) && (item.char_in <= CH_NINE);
  assign wr_data  = item.char_in;
  assign wr_en    = wr_hit & accept;

  always_comb begin
    fb = item.first_byte | item.first_of_query;
    if (item.first_of_query) begin
      in_blank_run_next   = 1'b0;
      literal_run_next    = 2'd0;
      pending_comma_next  = 1'b0;
      pending_space_next  = 1'b0;
      at_query_start_next = 1'b1;
      token_mode_next     = MODE_DROP;
      ident_length_next   = '0;
      digit_count_next    = 2'd0;
      ident_complex_next  = 1'b0;
    end else begin
      in_blank_run_next   = in_blank_run;
      literal_run_next    = literal_run;
      pending_comma_next  = pending_comma;
      pending_space_next  = pending_space;
      at_query_start_next = at_query_start;
      token_mode_next     = token_mode;
      ident_length_next   = ident_length;
      digit_count_next    = digit_count;
      ident_complex_next  = ident_complex;
    end
    plan      = '{mask: '0, chr: item.char_in, done: 1'b0};
    drain_len = '0;
    wr_hit    = 1'b0;
    wr_addr   = ident_length_next[ADDR_W-1:0];
    was_start = at_query_start_next;
    go_on     = (token_mode_next != MODE_OVER);
    skip      = 1'b0;

    if (go_on && fb) begin
      at_query_start_next = 1'b0;
      token_mode_next     = MODE_DROP;
      ident_length_next   = '0;
      digit_count_next    = 2'd0;
      ident_complex_next  = 1'b0;
      if (cls == CLS_BLANK) begin
        if (!in_blank_run_next) begin
          if (literal_run_next == 2'd0) begin
            if (!was_start) begin
              plan.mask[SLOT_BLANK] = 1'b1;
            end
          end else begin
            pending_space_next = 1'b1;
          end
        end
        in_blank_run_next = 1'b1;
      end else begin
        in_blank_run_next = 1'b0;
        if (cls == CLS_LITERAL) begin
          if (literal_run_next == 2'd0) begin
            plan.mask[SLOT_QMARK] = 1'b1;
          end
          if (literal_run_next != 2'd2) begin
            literal_run_next = literal_run_next + 2'd1;
          end
          pending_space_next = 1'b0;
          pending_comma_next = 1'b0;
        end else if (cls == CLS_COMMA && literal_run_next != 2'd0) begin
          pending_comma_next = 1'b1;
        end else if ((cls == CLS_PLUS || cls == CLS_MINUS) && pending_comma_next) begin
          // sign after a held comma is dropped
        end else begin
          // flush held text
          if (literal_run_next == 2'd2) begin
            plan.mask[SLOT_DOT_A] = 1'b1;
            plan.mask[SLOT_DOT_B] = 1'b1;
          end
          plan.mask[SLOT_COMMA] = pending_comma_next;
          plan.mask[SLOT_SPACE] = pending_space_next;
          literal_run_next   = 2'd0;
          pending_comma_next = 1'b0;
          pending_space_next = 1'b0;
          if (cls == CLS_END || cls == CLS_ERROR) begin
            token_mode_next = MODE_OVER;
            plan.done       = 1'b1;
            go_on           = 1'b0;
          end else if ((cls == CLS_QUOTED || (cls == CLS_WORD && !item.next_is_paren))
                       && !verbatim_names) begin
            token_mode_next = MODE_BUF;
          end else begin
            token_mode_next = MODE_COPY;
          end
        end
      end
    end

    if (go_on) begin
      if (token_mode_next == MODE_COPY) begin
        plan.mask[SLOT_COPY] = 1'b1;
      end else if (token_mode_next == MODE_BUF && !ident_complex_next) begin
        if (is_space) begin
          ident_complex_next = 1'b1;
        end else begin
          if (is_digit) begin
            if (digit_count_next != 2'd3) begin
              digit_count_next = digit_count_next + 2'd1;
            end
            if (digit_count_next == 2'd3) begin
              ident_complex_next = 1'b1;
              skip               = 1'b1;
            end
          end
          if (!skip) begin
            if (ident_length_next < LEN_W'(IDENT_LIMIT)) begin
              wr_hit            = 1'b1;
              wr_addr           = ident_length_next[ADDR_W-1:0];
              ident_length_next = ident_length_next + LEN_W'(1);
            end
            if (ident_length_next >= LEN_W'(IDENT_LIMIT)) begin
              ident_complex_next = 1'b1;
            end
          end
        end
      end

      if (item.last_byte) begin
        if (token_mode_next == MODE_BUF) begin
          if (ident_complex_next) begin
            plan.mask[SLOT_BQ_A] = 1'b1;
            plan.mask[SLOT_HIDE] = 1'b1;
            plan.mask[SLOT_BQ_B] = 1'b1;
          end else begin
            drain_len = ident_length_next;
          end
        end
        token_mode_next    = MODE_DROP;
        ident_length_next  = '0;
        digit_count_next   = 2'd0;
        ident_complex_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verbatim_names <= 1'b0;
      in_blank_run   <= 1'b0;
      literal_run    <= 2'd0;
      pending_comma  <= 1'b0;
      pending_space  <= 1'b0;
      at_query_start <= 1'b1;
      token_mode     <= MODE_DROP;
      ident_length   <= '0;
      digit_count    <= 2'd0;
      ident_complex  <= 1'b0;
    end else begin
      if (cfg_we) begin
        verbatim_names <= cfg_keep;
      end
      if (accept) begin
        in_blank_run   <= in_blank_run_next;
        literal_run    <= literal_run_next;
        pending_comma  <= pending_comma_next;
        pending_space  <= pending_space_next;
        at_query_start <= at_query_start_next;
        token_mode     <= token_mode_next;
        ident_length   <= ident_length_next;
        digit_count    <= digit_count_next;
        ident_complex  <= ident_complex_next;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/qtn_emit_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtn_emit_seq: result sequencer
// sends the fixed characters of a plan, then drains the identifier buffer
// ----------------------------------------------------------------------------
module qtn_emit_seq #(
  parameter int IDENT_LIMIT = qtn_pkg::IDENT_LIMIT_DEF,
  localparam int LEN_W  = $clog2(IDENT_LIMIT + 1),
  localparam int ADDR_W = $clog2(IDENT_LIMIT)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  qtn_pkg::plan_t     plan,
  input  logic [LEN_W-1:0]   drain_len,
  output logic               busy,
  output logic               rd_en,
  output logic [ADDR_W-1:0]  rd_addr,
  input  logic [7:0]         rd_data,
  output qtn_pkg::res_item_t res_item,
  output logic               res_valid,
  input  logic               res_stall
);
  import qtn_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIXED,
    S_READ,
    S_SEND
  } state_t;

  state_t            state;
  slot_mask_t        mask;
  slot_mask_t        low;
  slot_mask_t        rest;
  logic [7:0]        chr;
  logic [7:0]        pick;
  logic              done;
  logic [LEN_W-1:0]  dlen;
  logic [ADDR_W-1:0] idx;
  logic              out_free;
  logic              send;

  assign busy     = (state != S_IDLE);
  assign rd_en    = (state == S_READ);
  assign rd_addr  = idx;
  assign out_free = !res_valid || !res_stall;
  assign send     = out_free && (state == S_FIXED || state == S_SEND);
  assign low      = mask & (~mask + slot_mask_t'(1));
  assign rest     = mask & ~low;

  always_comb begin
    pick = 8'h00;
    for (int i = 0; i < NSLOT; i++) begin
      if (low[i]) begin
        pick = slot_char(i, chr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (send) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (load) begin
            mask <= plan.mask;
            chr  <= plan.chr;
            done <= plan.done;
            dlen <= drain_len;
            idx  <= '0;
            if (plan.mask != '0 || plan.done) begin
              state <= S_FIXED;
            end else if (drain_len != '0) begin
              state <= S_READ;
            end
          end
        end
        S_FIXED: begin
          if (out_free) begin
            if (mask == '0) begin
              // end of query with nothing held
              res_item <= '{char_out: 8'h00, char_valid: 1'b0, query_done: 1'b1};
            end else begin
              res_item <= '{char_out: pick, char_valid: 1'b1,
                            query_done: done && (rest == '0)};
            end
            mask <= rest;
            if (rest == '0) begin
              state <= (dlen != '0) ? S_READ : S_IDLE;
            end
          end
        end
        S_READ: begin
          state <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            res_item  <= '{char_out: rd_data, char_valid: 1'b1, query_done: 1'b0};
            idx       <= idx + ADDR_W'(1);
            if (LEN_W'(idx) + LEN_W'(1) == dlen) begin
              state <= S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: query text normaliser
// Drives lexed token bytes through the block, runs them through an
// independent prediction of the normalised text, and checks every result
// byte in order. Random bursts and gaps on the input, a shifting stall
// pattern on the output, and the name mode changed between phases.
// ----------------------------------------------------------------------------
module testbench;
  import qtn_pkg::*;

  localparam int NAME_MAX      = IDENT_LIMIT_DEF;
  localparam int RES_CAP       = 36;
  localparam int IDLE_LIMIT    = 2000;
  localparam int TAIL_CYCLES   = 100;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 50;
  localparam int N_PHASES      = 4;
  localparam int MAX_ERR_LINES = 30;

  // token classes the package leaves unnamed
  localparam logic [3:0] CLS_OTHER    = 4'd7;
  localparam logic [3:0] CLS_SPARE_LO = 4'd10;
  localparam logic [3:0] CLS_SPARE_HI = 4'd15;

  typedef enum logic [1:0] {TOK_DROP, TOK_COPY, TOK_BUFFER, TOK_OVER} tok_mode_e;
  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_RUNS} stall_pat_e;

  // --------------------------------------------------------------------------
  // normalised text prediction and in-order result checking
  // --------------------------------------------------------------------------
  class norm_scoreboard;
    bit         verbatim_names;
    bit         blank_run;
    bit [1:0]   lit_run;
    bit         pend_comma;
    bit         pend_space;
    bit         query_start;
    tok_mode_e  mode;
    logic [7:0] name_buf [NAME_MAX];
    int         name_len;
    bit [1:0]   digits;
    bit         name_complex;
    res_item_t  step_q[$];
    res_item_t  text_q[$];
    int         errors;
    int         live_bytes;
    int         result_bytes;
    int         names_hidden;

    function new();
      verbatim_names = 1'b0;
      errors         = 0;
      live_bytes     = 0;
      result_bytes   = 0;
      names_hidden   = 0;
      restart_query();
    endfunction

    function void restart_query();
      blank_run    = 1'b0;
      lit_run      = 2'd0;
      pend_comma   = 1'b0;
      pend_space   = 1'b0;
      query_start  = 1'b1;
      mode         = TOK_DROP;
      name_len     = 0;
      digits       = 2'd0;
      name_complex = 1'b0;
    endfunction

    function void emit(logic [7:0] ch);
      res_item_t r;
      if (step_q.size() >= RES_CAP) return;
      r.char_out   = ch;
      r.char_valid = 1'b1;
      r.query_done = 1'b0;
      step_q.insert(step_q.size(), r);
    endfunction

    // one byte of an identifier that may have to be hidden
    function void absorb_name(logic [7:0] ch);
      if (name_complex) return;
      if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
        name_complex = 1'b1;
        return;
      end
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        if (digits < 2'd3) digits++;
        if (digits == 2'd3) begin
          name_complex = 1'b1;
          return;
        end
      end
      if (name_len < NAME_MAX) begin
        name_buf[name_len] = ch;
        name_len++;
      end
      if (name_len >= NAME_MAX) name_complex = 1'b1;
    endfunction

    function void flush_held();
      if (lit_run > 2'd1) begin
        emit(CH_DOT);
        emit(CH_DOT);
      end
      if (pend_comma) emit(CH_COMMA);
      if (pend_space) emit(CH_SPACE);
      lit_run    = 2'd0;
      pend_comma = 1'b0;
      pend_space = 1'b0;
    endfunction

    function void close_name();
      mode         = TOK_DROP;
      name_len     = 0;
      digits       = 2'd0;
      name_complex = 1'b0;
    endfunction

    // works out the result bytes of one accepted input byte
    function void note_input(in_item_t it);
      bit         fb;
      bit         was_start;
      logic [3:0] cls;
      res_item_t  tail;
      fb  = it.first_byte;
      cls = it.token_class;
      step_q.delete();
      if (it.first_of_query) begin
        restart_query();
        fb = 1'b1;
      end
      if (mode == TOK_OVER) return;
      live_bytes++;
      if (fb) begin
        was_start   = query_start;
        query_start = 1'b0;
        close_name();
        if (cls == CLS_BLANK) begin
          if (!blank_run) begin
            if (lit_run == 2'd0) begin
              if (!was_start) emit(CH_SPACE);
            end else begin
              pend_space = 1'b1;
            end
          end
          blank_run = 1'b1;
        end else begin
          blank_run = 1'b0;
          if (cls == CLS_LITERAL) begin
            if (lit_run == 2'd0) emit(CH_QMARK);
            if (lit_run < 2'd2) lit_run++;
            pend_space = 1'b0;
            pend_comma = 1'b0;
          end else if (cls == CLS_COMMA && lit_run != 2'd0) begin
            pend_comma = 1'b1;
          end else if ((cls == CLS_PLUS || cls == CLS_MINUS) && pend_comma) begin
            // sign straight after a held comma vanishes
          end else begin
            flush_held();
            if (cls == CLS_END || cls == CLS_ERROR) begin
              mode = TOK_OVER;
              if (step_q.size() == 0) tail = '0;
              else tail = step_q.pop_back();
              tail.query_done = 1'b1;
              step_q.insert(step_q.size(), tail);
            end else if ((cls == CLS_QUOTED || (cls == CLS_WORD && !it.next_is_paren))
                         && !verbatim_names) begin
              mode = TOK_BUFFER;
            end else begin
              mode = TOK_COPY;
            end
          end
        end
      end
      if (mode == TOK_COPY) emit(it.char_in);
      else if (mode == TOK_BUFFER) absorb_name(it.char_in);
      if (it.last_byte && mode != TOK_OVER) begin
        if (mode == TOK_BUFFER) begin
          if (name_complex) begin
            names_hidden++;
            emit(CH_BQUOTE);
            emit(CH_QMARK);
            emit(CH_BQUOTE);
          end else begin
            for (int i = 0; i < name_len; i++) emit(name_buf[i]);
          end
        end
        close_name();
      end
      foreach (step_q[i]) text_q.insert(text_q.size(), step_q[i]);
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= MAX_ERR_LINES)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      result_bytes++;
      if (text_q.size() == 0) begin
        errors++;
        if (errors <= MAX_ERR_LINES)
          $display("%0t: result with nothing expected, expected none, got %h/%b/%b",
                   $time, got.char_out, got.char_valid, got.query_done);
        return;
      end
      want = text_q.pop_front();
      if (got.char_out !== want.char_out) report("char_out", want.char_out, got.char_out);
      if (got.char_valid !== want.char_valid)
        report("char_valid", 8'(want.char_valid), 8'(got.char_valid));
      if (got.query_done !== want.query_done)
        report("query_done", 8'(want.query_done), 8'(got.query_done));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and the block under test
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst;
  in_item_t  in_item;
  logic      in_valid;
  logic      in_stall;
  res_item_t res_item;
  logic      res_valid;
  logic      res_stall = 1'b0;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  norm_scoreboard sb = new();

  int         idle_cycles = 0;
  int         cfg_writes  = 0;
  int         queries     = 0;
  int         burst_left  = 0;
  bit         calm_sender = 1'b0;
  stall_pat_e stall_pat   = STALL_NONE;
  int         pat_left    = 0;
  int         run_left    = 0;

  query_text_normalizer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .res_item  (res_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // sampling at the rising edge: results checked before the new input is
  // noted, config transfers update the predicted register, and a watchdog
  // counts edges with no transfer at all
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) sb.check_result(res_item);
      if (in_valid && !in_stall) sb.note_input(in_item);
      if (cfg_valid && cfg_ready) begin
        sb.verbatim_names = cfg_data;
        cfg_writes++;
      end
      if ((res_valid && !res_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, sb.text_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver stall: switches between no stall, sparse single stalls and
  // longer on/off runs, each kept for a random stretch
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        stall_pat = stall_pat_e'($urandom_range(0, 2));
        pat_left  = $urandom_range(40, 150);
      end else begin
        pat_left--;
      end
      case (stall_pat)
        STALL_NONE: begin
          res_stall <= 1'b0;
        end
        STALL_SPARSE: begin
          res_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          if (run_left == 0) begin
            res_stall <= ~res_stall;
            run_left  = $urandom_range(1, 8);
          end else begin
            run_left--;
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t mk(input bit fq, input logic [3:0] cls, input bit fb,
                                  input bit lb, input bit paren, input logic [7:0] ch);
    in_item_t it;
    it.first_of_query = fq;
    it.token_class    = cls;
    it.first_byte     = fb;
    it.last_byte      = lb;
    it.next_is_paren  = paren;
    it.char_in        = ch;
    return it;
  endfunction

  // random garbage byte, never a query start
  function automatic in_item_t noise_byte();
    logic [$bits(in_item_t)-1:0] raw;
    in_item_t                    it;
    raw = $bits(in_item_t)'($urandom);
    it  = in_item_t'(raw);
    it.first_of_query = 1'b0;
    return it;
  endfunction

  // identifier bytes: mostly letters, some digits, whitespace and raw bytes
  function automatic logic [7:0] name_char(input bit plain);
    int r;
    r = plain ? 0 : $urandom_range(0, 19);
    if (r < 14) return "a" + 8'($urandom_range(0, 25));
    if (r < 17) return CH_ZERO + 8'($urandom_range(0, 9));
    if (r == 17) return ($urandom_range(0, 5) == 0) ? CH_SPACE
                                                   : CH_TAB + 8'($urandom_range(0, 4));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] token_char(input logic [3:0] cls, input bit plain);
    case (cls)
      CLS_BLANK: begin
        case ($urandom_range(0, 3))
          0:       return CH_SPACE;
          1:       return CH_TAB;
          2:       return "-";
          default: return "/";
        endcase
      end
      CLS_LITERAL: return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : CH_ZERO + 8'($urandom_range(0, 9));
      CLS_COMMA:   return CH_COMMA;
      CLS_PLUS:    return "+";
      CLS_MINUS:   return "-";
      CLS_QUOTED, CLS_WORD: return name_char(plain);
      default:     return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one input transfer; the sender then keeps going or takes a gap
  task automatic push_byte(input in_item_t it);
    int gap;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (!calm_sender) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 10);
        burst_left = $urandom_range(0, 7);
        in_valid  <= 1'b0;
        repeat (gap) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_token(input logic [3:0] cls, input int len, input bit fq,
                            input bit paren, input bit drop_last, input bit plain);
    in_item_t it;
    for (int k = 0; k < len; k++) begin
      it = mk(fq && k == 0, cls, k == 0, k == len - 1 && !drop_last,
              (k == 0) ? paren : bit'($urandom_range(0, 1)), token_char(cls, plain));
      push_byte(it);
    end
  endtask

  // wait for the block to go idle before changing the name mode
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.text_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_keep(input bit v);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hand-picked query covering the special cases one by one
  task automatic directed_part();
    push_byte(mk(1, CLS_BLANK,   1, 1, 0, CH_SPACE)); // blank at query start, no space
    push_byte(mk(0, CLS_WORD,    1, 0, 0, "a"));      // simple name kept
    push_byte(mk(0, CLS_WORD,    0, 1, 0, "b"));
    push_byte(mk(0, CLS_BLANK,   1, 1, 0, CH_TAB));
    push_byte(mk(0, CLS_LITERAL, 1, 1, 0, "7"));
    push_byte(mk(0, CLS_COMMA,   1, 1, 0, CH_COMMA)); // comma held after literal
    push_byte(mk(0, CLS_PLUS,    1, 1, 0, "+"));      // sign after held comma dropped
    push_byte(mk(0, CLS_LITERAL, 1, 1, 0, "8"));      // literal run of two
    push_byte(mk(0, CLS_BLANK,   1, 1, 0, CH_SPACE)); // space held behind literals
    push_byte(mk(0, CLS_COMMA,   1, 1, 0, CH_COMMA));
    push_byte(mk(0, CLS_OTHER,   1, 1, 1, 8'hFF));    // flushes dots, comma, space
    push_byte(mk(0, CLS_WORD,    1, 1, 1, "f"));      // function name copied
    push_byte(mk(0, CLS_QUOTED,  1, 0, 0, "a"));      // name with whitespace hidden
    push_byte(mk(0, CLS_QUOTED,  0, 0, 0, CH_SPACE));
    push_byte(mk(0, CLS_QUOTED,  0, 1, 0, "b"));
    push_byte(mk(0, CLS_WORD,    1, 0, 0, "1"));      // three digits hidden
    push_byte(mk(0, CLS_WORD,    0, 0, 0, "2"));
    push_byte(mk(0, CLS_WORD,    0, 1, 0, "3"));
    push_byte(mk(0, CLS_MINUS,   1, 1, 0, "-"));      // sign with nothing held, copied
    push_byte(mk(0, CLS_END,     1, 1, 0, 8'h00));    // query done
    push_byte(mk(0, CLS_OTHER,   1, 1, 0, "z"));      // ignored after the end
    push_byte(mk(1, CLS_SPARE_HI, 0, 0, 0, 8'h80));   // new query forces a token start
    push_byte(mk(0, CLS_WORD,    1, 0, 0, "q"));      // abandons the open token
    push_byte(mk(0, CLS_BLANK,   1, 1, 0, CH_SPACE)); // abandons the buffered name
    push_byte(mk(0, CLS_LITERAL, 0, 1, 0, "9"));      // stray continuation dropped
    push_byte(mk(0, CLS_ERROR,   1, 1, 0, "!"));      // error with nothing to flush
  endtask

  // a mostly well-formed random query, with the odd broken token
  task automatic send_query();
    int         ntok;
    int         len;
    int         r;
    logic [3:0] cls;
    bit         fq;
    bit         plain;
    queries++;
    ntok        = $urandom_range(1, 12);
    calm_sender = ($urandom_range(0, 3) == 0);
    fq          = 1'b1;
    for (int t = 0; t < ntok; t++) begin
      r     = $urandom_range(0, 99);
      plain = 1'b0;
      if (r < 14)      cls = CLS_BLANK;
      else if (r < 34) cls = CLS_LITERAL;
      else if (r < 46) cls = CLS_COMMA;
      else if (r < 51) cls = CLS_PLUS;
      else if (r < 56) cls = CLS_MINUS;
      else if (r < 64) cls = CLS_QUOTED;
      else if (r < 80) cls = CLS_WORD;
      else if (r < 97) cls = CLS_OTHER;
      else cls = 4'($urandom_range(CLS_SPARE_LO, CLS_SPARE_HI));
      if (cls == CLS_QUOTED || cls == CLS_WORD) begin
        // mostly short names, a few around the length limit
        r = $urandom_range(0, 99);
        if (r < 80) begin
          len = $urandom_range(1, 6);
        end else if (r < 92) begin
          len = $urandom_range(7, 20);
        end else begin
          len   = $urandom_range(NAME_MAX - 3, NAME_MAX + 4);
          plain = ($urandom_range(0, 9) < 7);
        end
      end else if (cls == CLS_BLANK || cls == CLS_LITERAL || cls == CLS_OTHER) begin
        len = $urandom_range(1, 3);
      end else begin
        len = 1;
      end
      send_token(cls, len, fq || ($urandom_range(0, 39) == 0), bit'($urandom_range(0, 1)),
                 $urandom_range(0, 19) == 0, plain);
      fq = 1'b0;
      if ($urandom_range(0, 29) == 0) push_byte(noise_byte());
    end
    if ($urandom_range(0, 9) != 0) begin
      send_token(($urandom_range(0, 3) == 0) ? CLS_ERROR : CLS_END, $urandom_range(1, 2),
                 1'b0, 1'b0, 1'b0, 1'b0);
      if ($urandom_range(0, 2) == 0) push_byte(noise_byte());
    end
  endtask

  // --------------------------------------------------------------------------
  // run: reset, directed query, then random phases with the name mode toggled
  // between them while the block is idle
  // --------------------------------------------------------------------------
  initial begin
    int start;
    int total_err;
    rst       = 1'b1;
    in_item   = '0;
    in_valid  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_keep(1'b0);
    directed_part();
    settle();
    write_keep(1'b1);

    for (int p = 0; p < N_PHASES; p++) begin
      start = sb.live_bytes;
      while (sb.live_bytes - start < PHASE_BYTES) send_query();
      settle();
      if (p < N_PHASES - 1) write_keep(p % 2 == 1);
    end

    // drain: the watchdog bounds this wait
    in_valid <= 1'b0;
    while (sb.text_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    total_err = sb.errors + sb.text_q.size();
    $display("run covered %0d live input bytes over %0d random queries plus a directed one,",
             sb.live_bytes, queries);
    $display("%0d result bytes checked, %0d names hidden, %0d name mode writes",
             sb.result_bytes, sb.names_hidden, cfg_writes);
    if (total_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
